@@ sv/srd_pkg.sv @@
package srd_pkg;

    localparam int unsigned MAX_NODE_COUNT_DEF = 8;
    localparam int unsigned NODE_IDS           = 8;
    localparam int unsigned CMD_DEPTH          = 2;
    localparam int unsigned OUT_DEPTH          = 2;

    localparam logic [31:0] PACKET_MAGIC = 32'h4e45_5421;
    localparam logic [31:0] NO_ROUTE     = 32'hffff_ffff;
    localparam logic [3:0]  EMPTY_SLOT   = 4'hf;

    // input action codes
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_PACKET = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // packet type codes
    localparam logic [1:0] PT_DISCOVER = 2'd1;
    localparam logic [1:0] PT_REPLY    = 2'd2;

    // result kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // configuration register indexes
    localparam logic CFG_MY_ID     = 1'b0;
    localparam logic CFG_NEIGHBORS = 1'b1;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_QUERY,
        OP_UPDATE
    } t_op;

    // one classified command from front to back
    typedef struct packed {
        t_op         op;
        logic [7:0]  send_mask;   // neighbors that get a discover copy
        logic        reply_ok;    // a reply follows the copies
        logic [2:0]  reply_hop;
        logic [2:0]  csrc;        // source field of discover copies
        logic [2:0]  rsrc;        // source field of the reply
        logic [2:0]  rdst;        // destination field of the reply
        logic [2:0]  node;        // table index for query and update
        logic [31:0] stamp;
        logic [31:0] path;
        logic [31:0] rtt;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [2:0]  next_hop;
        logic [2:0]  out_source;
        logic [2:0]  out_destination;
        logic [1:0]  out_type;
        logic [31:0] out_time;
        logic [31:0] out_path;
        logic [31:0] route_length;
        logic        last;
    } t_res;

    // Walk the path back from this node: {ok, hop}. ok low drops the reply.
    function automatic logic [3:0] back_hop(input logic [31:0] path, input logic [2:0] id,
                                            input int unsigned slots);
        logic [3:0] d;
        logic [3:0] s;
        logic       done;
        logic       ok;
        d    = path[3:0];
        done = 1'b0;
        ok   = 1'b1;
        for (int i = 1; i < 8; i++) begin
            s = path[4*i +: 4];
            if (!done && (i < slots)) begin
                if (s == EMPTY_SLOT) begin
                    ok   = 1'b0;
                    done = 1'b1;
                end else if (s == {1'b0, id}) begin
                    done = 1'b1;
                end else begin
                    d = s;
                end
            end
        end
        return {ok, d[2:0]};
    endfunction

endpackage

@@ sv/srd_fifo.sv @@
module srd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/srd_front.sv @@
module srd_front #(
    parameter int unsigned MAX_NODE_COUNT = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_push,
    input  logic [1:0]    i_action,
    input  logic [31:0]   i_magic,
    input  logic [1:0]    i_packet_type,
    input  logic [2:0]    i_pkt_source,
    input  logic [2:0]    i_pkt_destination,
    input  logic [31:0]   i_time_sent,
    input  logic [31:0]   i_path_in,
    input  logic [31:0]   i_now_time,
    input  logic [2:0]    i_query_node,
    input  logic          i_cmd_full,
    output logic          o_cmd_push,
    output srd_pkg::t_cmd o_cmd
);
    import srd_pkg::*;

    localparam int unsigned PATH_SLOTS = (MAX_NODE_COUNT < 8) ? MAX_NODE_COUNT : 8;

    logic [2:0]  r_my_id;
    logic [7:0]  r_neighbor_mask;
    logic        keep;
    logic        found;
    logic [31:0] new_path;
    logic [7:0]  seen;
    logic [3:0]  bh_disc;
    logic [3:0]  bh_fwd;
    logic        magic_ok;

    // find the first empty slot and stamp this node into it
    always_comb begin
        found    = 1'b0;
        new_path = i_path_in;
        for (int i = 0; i < 8; i++) begin
            if (!found && (i < PATH_SLOTS) && (i_path_in[4*i +: 4] == EMPTY_SLOT)) begin
                found             = 1'b1;
                new_path[4*i +: 4] = {1'b0, r_my_id};
            end
        end
    end

    // neighbors already on the extended path
    always_comb begin
        seen = '0;
        for (int nb = 0; nb < 8; nb++) begin
            for (int j = 0; j < 8; j++) begin
                if ((j < PATH_SLOTS) && (new_path[4*j +: 4] == 4'(nb))) begin
                    seen[nb] = 1'b1;
                end
            end
        end
    end

    assign bh_disc  = back_hop(new_path, r_my_id, PATH_SLOTS);
    assign bh_fwd   = back_hop(i_path_in, r_my_id, PATH_SLOTS);
    assign magic_ok = (i_magic == PACKET_MAGIC);

    always_comb begin
        keep  = 1'b0;
        o_cmd = '0;
        o_cmd.op = OP_SEND;
        case (i_action)
            ACT_START: begin
                keep            = (r_neighbor_mask != '0);
                o_cmd.send_mask = r_neighbor_mask;
                o_cmd.csrc      = r_my_id;
                o_cmd.stamp     = i_now_time;
                o_cmd.path      = {29'h1fff_fffe, r_my_id};
            end
            ACT_QUERY: begin
                keep       = 1'b1;
                o_cmd.op   = OP_QUERY;
                o_cmd.node = i_query_node;
            end
            ACT_PACKET: begin
                if (magic_ok && (i_packet_type == PT_DISCOVER)) begin
                    o_cmd.send_mask = r_neighbor_mask & ~seen;
                    o_cmd.reply_ok  = bh_disc[3];
                    o_cmd.reply_hop = bh_disc[2:0];
                    o_cmd.csrc      = i_pkt_source;
                    o_cmd.rsrc      = r_my_id;
                    o_cmd.rdst      = i_pkt_source;
                    o_cmd.stamp     = i_time_sent;
                    o_cmd.path      = new_path;
                    keep = found && (((r_neighbor_mask & ~seen) != '0) || bh_disc[3]);
                end else if (magic_ok && (i_packet_type == PT_REPLY)) begin
                    o_cmd.path = i_path_in;
                    if (i_pkt_destination == r_my_id) begin
                        keep       = 1'b1;
                        o_cmd.op   = OP_UPDATE;
                        o_cmd.node = i_pkt_source;
                        o_cmd.rtt  = i_now_time - i_time_sent;
                    end else begin
                        keep            = bh_fwd[3];
                        o_cmd.reply_ok  = bh_fwd[3];
                        o_cmd.reply_hop = bh_fwd[2:0];
                        o_cmd.rsrc      = i_pkt_source;
                        o_cmd.rdst      = i_pkt_destination;
                        o_cmd.stamp     = i_time_sent;
                    end
                end
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_cmd_push = i_push && !i_cmd_full && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id         <= '0;
            r_neighbor_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MY_ID:     r_my_id         <= i_cfg_data[2:0];
                CFG_NEIGHBORS: r_neighbor_mask <= i_cfg_data;
                default:       r_my_id         <= r_my_id;
            endcase
        end
    end

endmodule

@@ sv/srd_back.sv @@
module srd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  srd_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    input  logic          i_out_full,
    output logic          o_out_push,
    output srd_pkg::t_res o_res
);
    import srd_pkg::*;

    logic        r_busy, n_busy;
    t_cmd        r_cmd, n_cmd;
    logic [7:0]  r_mask, n_mask;
    logic [31:0] r_best_route [NODE_IDS];
    logic [31:0] r_best_time  [NODE_IDS];
    logic [2:0]  low_nb;
    logic [7:0]  rest;
    logic        upd;

    // lowest pending neighbor first
    always_comb begin
        low_nb = '0;
        for (int i = 7; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_nb = 3'(i);
            end
        end
    end

    assign rest = r_mask & (r_mask - 8'd1);

    always_comb begin
        n_busy     = r_busy;
        n_cmd      = r_cmd;
        n_mask     = r_mask;
        o_cmd_pop  = 1'b0;
        o_out_push = 1'b0;
        o_res      = '0;
        upd        = 1'b0;
        if (!r_busy) begin
            if (!i_cmd_empty) begin
                o_cmd_pop = 1'b1;
                n_cmd     = i_cmd;
                n_mask    = i_cmd.send_mask;
                n_busy    = 1'b1;
            end
        end else begin
            unique case (r_cmd.op)
                OP_SEND: begin
                    if (!i_out_full) begin
                        o_out_push     = 1'b1;
                        o_res.kind     = KIND_PACKET;
                        o_res.out_time = r_cmd.stamp;
                        o_res.out_path = r_cmd.path;
                        if (r_mask != '0) begin
                            o_res.next_hop        = low_nb;
                            o_res.out_source      = r_cmd.csrc;
                            o_res.out_destination = low_nb;
                            o_res.out_type        = PT_DISCOVER;
                            o_res.last            = (rest == '0) && !r_cmd.reply_ok;
                            n_mask                = rest;
                            if ((rest == '0) && !r_cmd.reply_ok) begin
                                n_busy = 1'b0;
                            end
                        end else begin
                            o_res.next_hop        = r_cmd.reply_hop;
                            o_res.out_source      = r_cmd.rsrc;
                            o_res.out_destination = r_cmd.rdst;
                            o_res.out_type        = PT_REPLY;
                            o_res.last            = 1'b1;
                            n_busy                = 1'b0;
                        end
                    end
                end
                OP_QUERY: begin
                    if (!i_out_full) begin
                        o_out_push         = 1'b1;
                        o_res.kind         = KIND_REPORT;
                        o_res.out_path     = r_best_route[r_cmd.node];
                        o_res.route_length = r_best_time[r_cmd.node];
                        o_res.last         = 1'b1;
                        n_busy             = 1'b0;
                    end
                end
                OP_UPDATE: begin
                    upd    = (r_best_time[r_cmd.node] > r_cmd.rtt);
                    n_busy = 1'b0;
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            for (int i = 0; i < NODE_IDS; i++) begin
                r_best_route[i] <= NO_ROUTE;
                r_best_time[i]  <= NO_ROUTE;
            end
        end else begin
            r_busy <= n_busy;
            if (upd) begin
                r_best_route[r_cmd.node] <= r_cmd.path;
                r_best_time[r_cmd.node]  <= r_cmd.rtt;
            end
        end
        r_cmd  <= n_cmd;
        r_mask <= n_mask;
    end

    a_send_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cmd.op == OP_SEND)) |-> ((r_mask != '0) || r_cmd.reply_ok))
        else $error("send command with nothing to emit");

    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_res.last) |=> !r_busy)
        else $error("back still busy after final word");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> !r_busy)
        else $error("command popped while busy");

    a_report_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && (o_res.kind == KIND_REPORT)) |-> o_res.last)
        else $error("route report not marked final");

endmodule

@@ sv/source_route_discovery_node.sv @@
// Path: an accepted word passes the command queue, then the back sequencer's
//   command register, before its first result enters the result queue.
// Flow: the back sequencer loads one command at a time and emits its words
//   one per cycle while the result queue has room; a stored reply emits none.
// Reset: synchronous, active low; clears config, both queues and the route
//   table (every route empty, every time all ones).
module source_route_discovery_node #(
    parameter int unsigned MAX_NODE_COUNT = srd_pkg::MAX_NODE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_magic,
    input  logic [1:0]  i_packet_type,
    input  logic [2:0]  i_pkt_source,
    input  logic [2:0]  i_pkt_destination,
    input  logic [31:0] i_time_sent,
    input  logic [31:0] i_path_in,
    input  logic [31:0] i_now_time,
    input  logic [2:0]  i_query_node,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [2:0]  o_next_hop,
    output logic [2:0]  o_out_source,
    output logic [2:0]  o_out_destination,
    output logic [1:0]  o_out_type,
    output logic [31:0] o_out_time,
    output logic [31:0] o_out_path,
    output logic [31:0] o_route_length,
    output logic        o_last
);
    import srd_pkg::*;

    localparam int unsigned CMD_W = $bits(t_cmd);
    localparam int unsigned RES_W = $bits(t_res);

    t_cmd             fr_cmd;
    logic             fr_push;
    logic [CMD_W-1:0] cq_data;
    logic             cq_empty;
    logic             bk_pop;
    t_res             bk_res;
    logic             bk_push;
    logic             oq_full;
    logic [RES_W-1:0] oq_data;
    t_res             res;

    // Front: hold config, classify each word, drop bad or empty work, and
    // precompute the extended path, the flood mask and the reply hop.
    srd_front #(
        .MAX_NODE_COUNT (MAX_NODE_COUNT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_push            (push),
        .i_action          (i_action),
        .i_magic           (i_magic),
        .i_packet_type     (i_packet_type),
        .i_pkt_source      (i_pkt_source),
        .i_pkt_destination (i_pkt_destination),
        .i_time_sent       (i_time_sent),
        .i_path_in         (i_path_in),
        .i_now_time        (i_now_time),
        .i_query_node      (i_query_node),
        .i_cmd_full        (full),
        .o_cmd_push        (fr_push),
        .o_cmd             (fr_cmd)
    );

    // Command queue: decouple classification from emission. Full backs up
    // the input side even for words that will be dropped.
    srd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_cmd),
        .o_full  (full),
        .i_pop   (bk_pop),
        .o_data  (cq_data),
        .o_empty (cq_empty)
    );

    // Back: walk the flood mask one neighbor per cycle (held on a full result
    // queue), then the reply; queries and rtt updates use the route table.
    srd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (t_cmd'(cq_data)),
        .i_cmd_empty (cq_empty),
        .o_cmd_pop   (bk_pop),
        .i_out_full  (oq_full),
        .o_out_push  (bk_push),
        .o_res       (bk_res)
    );

    // Result queue: hold finished words while the consumer stalls.
    srd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_push),
        .i_data  (bk_res),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_data),
        .o_empty (empty)
    );

    assign res               = t_res'(oq_data);
    assign o_kind            = res.kind;
    assign o_next_hop        = res.next_hop;
    assign o_out_source      = res.out_source;
    assign o_out_destination = res.out_destination;
    assign o_out_type        = res.out_type;
    assign o_out_time        = res.out_time;
    assign o_out_path        = res.out_path;
    assign o_route_length    = res.route_length;
    assign o_last            = res.last;

endmodule

@@ sim/source_route_discovery_node_test.sv @@
`timescale 1ns / 1ps

module source_route_discovery_node_test;
    import srd_pkg::*;

    // path slots that take part in the walk; bits above them ride along untouched
    localparam int TRAIL_SLOTS   = (MAX_NODE_COUNT_DEF < 8) ? MAX_NODE_COUNT_DEF : 8;
    // margin after the last expected word before touching the registers
    localparam int SETTLE_CYCLES = 24;
    // cycles with no word moving on either side before the run is abandoned
    localparam int QUIET_LIMIT   = 4000;
    localparam int CHUNKS        = 9;
    localparam int CHUNK_ITEMS   = 25;
    localparam int PRINT_LIMIT   = 200;

    // codes the block has no name for: they must be dropped
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [1:0] PT_NONE   = 2'd0;
    localparam logic [1:0] PT_SPARE  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] magic;
        logic [1:0]  ptype;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [31:0] tsent;
        logic [31:0] path;
        logic [31:0] now;
        logic [2:0]  query;
        logic        wait_clear;   // hold this word until every due word is out
    } t_node_word;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = CFG_MY_ID;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        push       = 1'b0;
    logic        pop        = 1'b0;
    t_node_word  cur        = '0;

    logic        full;
    logic        empty;
    logic        o_kind;
    logic [2:0]  o_next_hop;
    logic [2:0]  o_out_source;
    logic [2:0]  o_out_destination;
    logic [1:0]  o_out_type;
    logic [31:0] o_out_time;
    logic [31:0] o_out_path;
    logic [31:0] o_route_length;
    logic        o_last;

    // stimulus waiting to go in, and words the node must still put out
    t_node_word  offered_words [$];
    t_res        node_words_due [$];
    t_res        word_batch [$];

    // mirror of the node: its registers and its route table
    logic [2:0]  node_id;
    logic [7:0]  nbr_mask;
    logic [31:0] route_by_node [NODE_IDS];
    logic [31:0] rtt_by_node [NODE_IDS];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          word_taken = 1'b0;
    int          quiet_cycles = 0;
    int          fault_count = 0;
    int          words_checked = 0;

    logic [2:0]  phase_id [CHUNKS] =
        '{3'd7, 3'd0, 3'd3, 3'd5, 3'd1, 3'd6, 3'd4, 3'd2, 3'd7};
    logic [7:0]  phase_mask [CHUNKS] =
        '{8'h00, 8'hff, 8'h5a, 8'hff, 8'h81, 8'h00, 8'hff, 8'h7e, 8'hff};

    source_route_discovery_node dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_action          (cur.action),
        .i_magic           (cur.magic),
        .i_packet_type     (cur.ptype),
        .i_pkt_source      (cur.src),
        .i_pkt_destination (cur.dst),
        .i_time_sent       (cur.tsent),
        .i_path_in         (cur.path),
        .i_now_time        (cur.now),
        .i_query_node      (cur.query),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_next_hop        (o_next_hop),
        .o_out_source      (o_out_source),
        .o_out_destination (o_out_destination),
        .o_out_type        (o_out_type),
        .o_out_time        (o_out_time),
        .o_out_path        (o_out_path),
        .o_route_length    (o_route_length),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Node mirror
    // ------------------------------------------------------------------

    // Trace the path back from this node toward the originator. Return low when
    // an empty slot turns up before our own id; running off the end keeps the
    // value of the last slot.
    function automatic bit walk_back(input logic [31:0] path, output logic [2:0] hop);
        logic [3:0] prev;
        logic [3:0] s;
        bit         ok;
        prev = path[3:0];
        ok   = 1'b1;
        for (int i = 1; i < TRAIL_SLOTS; i++) begin
            s = path[4*i +: 4];
            if (s == EMPTY_SLOT) begin
                ok = 1'b0;
                break;
            end
            if (s == {1'b0, node_id})
                break;
            prev = s;
        end
        hop = prev[2:0];
        return ok;
    endfunction

    function automatic void add_packet(input logic [2:0] hop, input logic [2:0] src,
                                       input logic [2:0] dst, input logic [1:0] ptype,
                                       input logic [31:0] stamp, input logic [31:0] path);
        t_res r;
        r                 = '0;
        r.kind            = KIND_PACKET;
        r.next_hop        = hop;
        r.out_source      = src;
        r.out_destination = dst;
        r.out_type        = ptype;
        r.out_time        = stamp;
        r.out_path        = path;
        word_batch.push_back(r);
    endfunction

    // Work out every word one accepted input causes, and update the route table.
    function automatic void compute_node_words(input t_node_word w);
        t_res        r;
        logic [31:0] path;
        logic [31:0] rtt;
        logic [2:0]  hop;
        int          free_slot;
        bit          seen;
        word_batch.delete();
        path = w.path;
        if (w.action == ACT_START) begin
            // flood a fresh discover to every neighbor, lowest id first
            for (int nb = 0; nb < NODE_IDS; nb++)
                if (nbr_mask[nb])
                    add_packet(3'(nb), node_id, 3'(nb), PT_DISCOVER, w.now,
                               {28'hfffffff, 1'b0, node_id});
        end else if (w.action == ACT_QUERY) begin
            r              = '0;
            r.kind         = KIND_REPORT;
            r.out_path     = route_by_node[w.query];
            r.route_length = rtt_by_node[w.query];
            word_batch.push_back(r);
        end else if (w.action == ACT_PACKET && w.magic == PACKET_MAGIC) begin
            if (w.ptype == PT_DISCOVER) begin
                free_slot = TRAIL_SLOTS;
                for (int i = TRAIL_SLOTS - 1; i >= 0; i--)
                    if (path[4*i +: 4] == EMPTY_SLOT)
                        free_slot = i;
                // a full path is dropped outright
                if (free_slot < TRAIL_SLOTS) begin
                    path[4*free_slot +: 4] = {1'b0, node_id};
                    for (int nb = 0; nb < NODE_IDS; nb++) begin
                        if (nbr_mask[nb]) begin
                            seen = 1'b0;
                            for (int j = 0; j < TRAIL_SLOTS; j++)
                                if (path[4*j +: 4] == 4'(nb))
                                    seen = 1'b1;
                            if (!seen)
                                add_packet(3'(nb), w.src, 3'(nb), PT_DISCOVER, w.tsent, path);
                        end
                    end
                    if (walk_back(path, hop))
                        add_packet(hop, node_id, w.src, PT_REPLY, w.tsent, path);
                end
            end else if (w.ptype == PT_REPLY) begin
                if (w.dst == node_id) begin
                    // keep the route only on a strictly shorter round trip
                    rtt = w.now - w.tsent;
                    if (rtt < rtt_by_node[w.src]) begin
                        route_by_node[w.src] = path;
                        rtt_by_node[w.src]   = rtt;
                    end
                end else if (walk_back(path, hop)) begin
                    add_packet(hop, w.src, w.dst, PT_REPLY, w.tsent, path);
                end
            end
        end
        if (word_batch.size() != 0) begin
            r      = word_batch.pop_back();
            r.last = 1'b1;
            word_batch.push_back(r);
        end
        foreach (word_batch[k])
            node_words_due.push_back(word_batch[k]);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_fault(input string msg);
        if (fault_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_fault($sformatf("word %0d %s: got %h, expected %h",
                                   words_checked, name, got, want));
    endtask

    task automatic check_word();
        t_res got;
        t_res want;
        got = {o_kind, o_next_hop, o_out_source, o_out_destination, o_out_type,
               o_out_time, o_out_path, o_route_length, o_last};
        if (node_words_due.size() == 0) begin
            report_fault($sformatf("word %0d not expected: kind %0d path %h",
                                   words_checked, got.kind, got.out_path));
        end else begin
            want = node_words_due.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("next_hop", 32'(got.next_hop), 32'(want.next_hop));
            compare_field("out_source", 32'(got.out_source), 32'(want.out_source));
            compare_field("out_destination", 32'(got.out_destination),
                          32'(want.out_destination));
            compare_field("out_type", 32'(got.out_type), 32'(want.out_type));
            compare_field("out_time", got.out_time, want.out_time);
            compare_field("out_path", got.out_path, want.out_path);
            compare_field("route_length", got.route_length, want.route_length);
            compare_field("last", 32'(got.last), 32'(want.last));
        end
        words_checked++;
    endtask

    // Sample both handshakes at the rising edge; predict on every accepted
    // input word and check every accepted result word.
    always @(posedge i_clk) begin
        word_taken = i_rst_n && push && !full;
        if (word_taken)
            compute_node_words(cur);
        if (i_rst_n && pop && !empty)
            check_word();
        // watchdog: give up after a long stretch with nothing moving
        if (word_taken || (i_rst_n && pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("source_route_discovery_node verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving, all on the falling edge
    // ------------------------------------------------------------------

    // Sender: hold a word until it is taken, then load the next one or idle.
    always @(negedge i_clk) begin
        bit go;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || word_taken) begin
            go = offered_words.size() != 0 && $urandom_range(99) >= send_idle_pct;
            // a marked word waits for the node to drain completely
            if (go && offered_words[0].wait_clear && node_words_due.size() != 0)
                go = 1'b0;
            if (go) begin
                cur  <= offered_words.pop_front();
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: stall at random.
    always @(negedge i_clk)
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic offer(input logic [1:0] action, input logic [31:0] magic,
                         input logic [1:0] ptype, input logic [2:0] src,
                         input logic [2:0] dst, input logic [31:0] tsent,
                         input logic [31:0] path, input logic [31:0] now,
                         input logic [2:0] query, input bit hold = 1'b0);
        t_node_word w;
        w = '{action, magic, ptype, src, dst, tsent, path, now, query, hold};
        offered_words.push_back(w);
    endtask

    // Build a path of k distinct ids other than ours, slot 0 first; optionally
    // splice our own id in at a random position.
    function automatic logic [31:0] chain_path(input int k, input bit with_self);
        logic [2:0]  pool [$];
        logic [2:0]  t;
        logic [31:0] path;
        int          j;
        for (int n = 0; n < NODE_IDS; n++)
            if (3'(n) != node_id)
                pool.push_back(3'(n));
        for (int n = pool.size() - 1; n > 0; n--) begin
            j       = $urandom_range(n);
            t       = pool[n];
            pool[n] = pool[j];
            pool[j] = t;
        end
        while (pool.size() > k)
            void'(pool.pop_back());
        if (with_self)
            pool.insert($urandom_range(pool.size()), node_id);
        path = '1;
        foreach (pool[n])
            path[4*n +: 4] = {1'b0, pool[n]};
        return path;
    endfunction

    // Mostly well-formed traffic with random content, the rest noise.
    // counted drops low for bad magic, unknown codes and full discover paths.
    function automatic t_node_word random_word(output bit counted);
        t_node_word w;
        int         pick;
        w            = '0;
        w.magic      = PACKET_MAGIC;
        w.src        = 3'($urandom_range(7));
        w.dst        = 3'($urandom_range(7));
        w.tsent      = $urandom;
        w.now        = $urandom;
        w.path       = $urandom;
        w.query      = 3'($urandom_range(7));
        w.wait_clear = ($urandom_range(49) == 0);
        counted      = 1'b1;
        pick         = $urandom_range(99);
        if (pick < 10) begin
            w.action = ACT_START;
        end else if (pick < 22) begin
            w.action = ACT_QUERY;
        end else if (pick < 50) begin
            w.action = ACT_PACKET;
            w.ptype  = PT_DISCOVER;
            w.path   = chain_path($urandom_range(7), $urandom_range(4) == 0);
            counted  = (w.path[31:28] == EMPTY_SLOT);
        end else if (pick < 82) begin
            w.action = ACT_PACKET;
            w.ptype  = PT_REPLY;
            if ($urandom_range(1) != 0) begin
                // reply coming home: short round trips so ties and wins both happen
                w.dst  = node_id;
                w.path = chain_path($urandom_range(1, 7), 1'b1);
                if ($urandom_range(3) != 0)
                    w.now = w.tsent + $urandom_range(24);
            end else begin
                w.path = chain_path($urandom_range(1, 7), $urandom_range(4) != 0);
            end
        end else begin
            w.action = ACT_PACKET;
            case ($urandom_range(4))
                0: begin
                    w.magic = $urandom;
                    w.ptype = 2'($urandom_range(3));
                    counted = 1'b0;
                end
                1: begin
                    w.ptype = ($urandom_range(1) != 0) ? PT_NONE : PT_SPARE;
                    counted = 1'b0;
                end
                2: begin
                    w.action = ACT_SPARE;
                    w.magic  = $urandom;
                    w.ptype  = 2'($urandom_range(3));
                    counted  = 1'b0;
                end
                default: begin
                    // arbitrary path bits: any slot value, empty or past the last id
                    w.ptype = ($urandom_range(1) != 0) ? PT_DISCOVER : PT_REPLY;
                end
            endcase
        end
        return w;
    endfunction

    // Wait until nothing is queued or due, then let stragglers drain.
    task automatic wait_idle();
        while (offered_words.size() != 0 || push || node_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [2:0] id, input logic [7:0] mask);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MY_ID;
        i_cfg_data <= {5'($urandom), id};   // only the low bits are the id
        @(negedge i_clk);
        i_cfg_idx  <= CFG_NEIGHBORS;
        i_cfg_data <= mask;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        node_id  = id;
        nbr_mask = mask;
    endtask

    initial begin
        t_node_word w;
        bit         counted;
        int         made;
        logic [7:0] mask;

        for (int n = 0; n < NODE_IDS; n++) begin
            route_by_node[n] = NO_ROUTE;
            rtt_by_node[n]   = NO_ROUTE;
        end
        node_id       = '0;
        nbr_mask      = '0;
        send_idle_pct = 32;
        recv_idle_pct = 75;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at their reset values: no neighbors, empty table
        offer(ACT_START, PACKET_MAGIC, PT_DISCOVER, 3'd0, 3'd0, 32'h0, 32'h0,
              32'h1234_5678, 3'd0);
        offer(ACT_QUERY, PACKET_MAGIC, PT_DISCOVER, 3'd0, 3'd0, 32'h0, 32'h0,
              32'h0, 3'd7);
        wait_idle();

        // every node a neighbor, our own bit included
        configure(3'd2, 8'hff);
        offer(ACT_START, PACKET_MAGIC, PT_DISCOVER, 3'd0, 3'd0, 32'h0, 32'h0,
              32'hffff_ffff, 3'd0);
        offer(ACT_PACKET, PACKET_MAGIC, PT_DISCOVER, 3'd5, 3'd1, 32'h0000_1000,
              32'hffff_ff15, 32'h0, 3'd0);
        // full path: drop
        offer(ACT_PACKET, PACKET_MAGIC, PT_DISCOVER, 3'd3, 3'd0, 32'h7,
              32'h7654_3210, 32'h0, 3'd0);
        // empty path: copies go out, the reply finds no way back
        offer(ACT_PACKET, PACKET_MAGIC, PT_DISCOVER, 3'd4, 3'd0, 32'h9,
              32'hffff_ffff, 32'h0, 3'd0);
        // we take the last free slot; every neighbor already seen
        offer(ACT_PACKET, PACKET_MAGIC, PT_DISCOVER, 3'd0, 3'd0, 32'hffff_ffff,
              32'hf765_4310, 32'h0, 3'd0);
        // bad magic, unknown types, unknown action
        offer(ACT_PACKET, 32'hffff_ffff, PT_DISCOVER, 3'd7, 3'd7, 32'h1,
              32'hffff_ff10, 32'h0, 3'd0);
        offer(ACT_PACKET, PACKET_MAGIC, PT_NONE, 3'd1, 3'd2, 32'h1,
              32'hffff_ff10, 32'h0, 3'd0);
        offer(ACT_PACKET, PACKET_MAGIC, PT_SPARE, 3'd1, 3'd2, 32'h1,
              32'hffff_ff10, 32'h0, 3'd0);
        offer(ACT_SPARE, 32'h0000_0000, PT_REPLY, 3'd1, 3'd2, 32'h1,
              32'hffff_ff10, 32'h0, 3'd7);
        // replies for us: store, tie keeps the old route, wrapped time wins
        offer(ACT_PACKET, PACKET_MAGIC, PT_REPLY, 3'd4, 3'd2, 32'd100,
              32'hffff_f024, 32'd150, 3'd0);
        offer(ACT_PACKET, PACKET_MAGIC, PT_REPLY, 3'd4, 3'd2, 32'd200,
              32'hffff_f314, 32'd250, 3'd0);
        offer(ACT_PACKET, PACKET_MAGIC, PT_REPLY, 3'd4, 3'd2, 32'hffff_fff0,
              32'hffff_f714, 32'd14, 3'd0);
        // read back only once the node has gone quiet
        offer(ACT_QUERY, PACKET_MAGIC, PT_DISCOVER, 3'd0, 3'd0, 32'h0, 32'h0,
              32'h0, 3'd4, 1'b1);
        // forwarded reply stepping back past us
        offer(ACT_PACKET, PACKET_MAGIC, PT_REPLY, 3'd5, 3'd6, 32'h55,
              32'hffff_5236, 32'h0, 3'd0);
        // no empty slot and no own id: the last slot decides
        offer(ACT_PACKET, PACKET_MAGIC, PT_REPLY, 3'd1, 3'd0, 32'h66,
              32'h9765_4310, 32'h0, 3'd0);
        // own id missing before an empty slot: drop
        offer(ACT_PACKET, PACKET_MAGIC, PT_REPLY, 3'd1, 3'd0, 32'h77,
              32'hffff_ff56, 32'h0, 3'd0);
        offer(ACT_PACKET, PACKET_MAGIC, PT_REPLY, 3'd3, 3'd0, 32'h88,
              32'hffff_ff42, 32'h0, 3'd0);
        offer(ACT_QUERY, PACKET_MAGIC, PT_DISCOVER, 3'd0, 3'd0, 32'h0, 32'h0,
              32'h0, 3'd0);
        offer(ACT_QUERY, PACKET_MAGIC, PT_DISCOVER, 3'd0, 3'd0, 32'h0, 32'h0,
              32'h0, 3'd7);
        wait_idle();

        // random traffic; idling pattern shifts every three chunks
        for (int c = 0; c < CHUNKS; c++) begin
            send_idle_pct = (c < 3) ? 32 : (c < 6) ? 75 : 0;
            recv_idle_pct = (c < 3) ? 75 : (c < 6) ? 32 : 0;
            mask = (c == 5) ? 8'($urandom) : phase_mask[c];
            configure(phase_id[c], mask);
            made = 0;
            while (made < CHUNK_ITEMS) begin
                w = random_word(counted);
                offered_words.push_back(w);
                if (counted)
                    made++;
            end
            wait_idle();
        end

        if (fault_count == 0)
            $display("source_route_discovery_node verification clean");
        else
            $display("source_route_discovery_node verification failed");
        $finish;
    end

endmodule
